FILE: src/huffman_packet_decoder_assert.svh
// Assertion macros shared by the decoder checkers.
// Needs a clock and an active-low reset name at each use; no other dependencies.
`ifndef HUFFMAN_PACKET_DECODER_ASSERT_SVH
`define HUFFMAN_PACKET_DECODER_ASSERT_SVH

// same-cycle implication
`define HFPD_AST_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rs) (ante) |-> (cons)) \
    else $error("hfpd check failed");

// next-cycle implication
`define HFPD_AST_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rs) (ante) |=> (cons)) \
    else $error("hfpd check failed");

`endif

FILE: src/hfpd_pkg.sv
// Types and constants of the Huffman packet decoder.
// No dependencies; imported by the node RAM and the top level.
`timescale 1ns / 1ps
`default_nettype none

package hfpd_pkg;

  // one tree node as held in the node memory
  typedef struct packed {
    logic       leaf;
    logic [8:0] zero_child;
    logic [8:0] one_child;
    logic [7:0] symbol;
  } hfpd_node_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FLUSH
  } hfpd_state_t;

  typedef enum logic [1:0] {
    MODE_HEADER,
    MODE_HUFF,
    MODE_RAW,
    MODE_BAD
  } hfpd_mode_t;

  localparam logic       OP_LOAD = 1'b0;
  localparam logic       OP_BYTE = 1'b1;

  localparam logic [7:0] HDR_RAW     = 8'hFF;
  localparam logic [7:0] HDR_PAD_LIM = 8'h08;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_CUT    = 2'd1;
  localparam logic [1:0] STAT_BADHDR = 2'd2;

endpackage

`default_nettype wire

FILE: src/hfpd_node_ram.sv
// Node memory of the decoder: one write port, one read port, registered read.
// Depends on hfpd_pkg for the node record type.
`timescale 1ns / 1ps
`default_nettype none

module hfpd_node_ram
  import hfpd_pkg::*;
#(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  wire logic       clk,
  input  wire logic       wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire hfpd_node_t wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output hfpd_node_t      rd_data
);

  hfpd_node_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: src/huffman_packet_decoder.sv
// Channel  Dir  tdata                                  tuser                  tlast
// in_      in   node/child/symbol/packet byte (48 b)    operation              last_byte
// out_     out  symbol (8 b)                           valid/run_last/status  packet_end
//
// Loads leave the decoder idle, ready for the next item; a packet byte moves it out of idle
// unless it is a non-final header or bad-packet byte. Each data bit of a Huffman byte is one
// read of the node memory whose address comes from the previous read.
// Results wait in an output register; a full output stalls the walk only when a second
// symbol is due. Reset (rst_n low, synchronous) returns to the root, awaiting a header;
// the node memory keeps its contents and is undefined until loaded.
// Depends on hfpd_pkg and hfpd_node_ram.
`timescale 1ns / 1ps
`default_nettype none

module huffman_packet_decoder
  import hfpd_pkg::*;
#(
  parameter int TREE_NODES = 512
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [8:0] node_index, [9] node_is_leaf, [18:10] zero_child, [27:19] one_child,
  // [35:28] leaf_symbol, [43:36] packet_byte, [47:44] zero
  input  wire logic [47:0] in_tdata,
  // [0] operation
  input  wire logic        in_tuser,
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [7:0] symbol
  output logic [7:0]       out_tdata,
  // [0] symbol_valid, [1] run_last, [3:2] end_status
  output logic [3:0]       out_tuser,
  output logic             out_tlast
);

  localparam int         AW        = $clog2(TREE_NODES);
  localparam logic [9:0] NODES_LIM = 10'(TREE_NODES);

  // input unpack
  logic [8:0] f_index;
  hfpd_node_t f_node;
  logic [7:0] f_byte;

  assign f_index           = in_tdata[8:0];
  assign f_node.leaf       = in_tdata[9];
  assign f_node.zero_child = in_tdata[18:10];
  assign f_node.one_child  = in_tdata[27:19];
  assign f_node.symbol     = in_tdata[35:28];
  assign f_byte            = in_tdata[43:36];

  hfpd_state_t state_r, state_nxt;
  hfpd_mode_t  mode_r, mode_nxt;
  logic [2:0]  pad_r, pad_nxt;
  logic [8:0]  walk_r, walk_nxt;
  logic        in_code_r, in_code_nxt;
  logic        held_v_r, held_v_nxt;
  logic        out_v_r, out_v_nxt;

  hfpd_node_t  cur_r, cur_nxt;
  hfpd_node_t  root_r, root_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        last_r, last_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic [2:0]  bit_end_r, bit_end_nxt;
  logic [8:0]  fetch_r;
  logic        oor_r;
  logic [7:0]  held_sym_r, held_sym_nxt;
  logic [7:0]  out_sym_r, out_sym_nxt;
  logic        out_sv_r, out_sv_nxt;
  logic        out_run_r, out_run_nxt;
  logic        out_pend_r, out_pend_nxt;
  logic [1:0]  out_stat_r, out_stat_nxt;

  logic        in_acc, load_acc, byte_acc, load_in_range;
  logic        out_free, walk_stall, walk_done, flush_need_out, flush_go;
  hfpd_node_t  rd_data, fetched, walk_cur;
  logic [8:0]  rd_idx;
  logic [2:0]  bit_inc;
  logic [1:0]  end_stat;

  function automatic logic [8:0] child_of(input hfpd_node_t n, input logic b);
    return b ? n.one_child : n.zero_child;
  endfunction

  assign in_tready     = (state_r == S_IDLE);
  assign in_acc        = in_tvalid && in_tready;
  assign load_acc      = in_acc && (in_tuser == OP_LOAD);
  assign byte_acc      = in_acc && (in_tuser == OP_BYTE);
  assign load_in_range = ({1'b0, f_index} < NODES_LIM);

  assign out_free       = !out_v_r || out_tready;
  assign fetched        = oor_r ? '0 : rd_data;
  assign walk_cur       = fetched.leaf ? root_r : fetched;
  assign walk_stall     = (state_r == S_WALK) && fetched.leaf && held_v_r && !out_free;
  assign walk_done      = (state_r == S_WALK) && !walk_stall && (bit_r == bit_end_r);
  assign flush_need_out = last_r || held_v_r;
  assign flush_go       = (state_r == S_FLUSH) && (!flush_need_out || out_free);
  assign bit_inc        = bit_r + 3'd1;
  assign end_stat       = (mode_r == MODE_BAD) ? STAT_BADHDR :
                          (in_code_r ? STAT_CUT : STAT_OK);

  // address of the next node read; a stalled walk re-reads the same node
  always_comb begin
    rd_idx = fetch_r;
    if (byte_acc && (mode_r == MODE_HUFF)) begin
      rd_idx = child_of(cur_r, f_byte[0]);
    end else if ((state_r == S_WALK) && !walk_stall && !walk_done) begin
      rd_idx = child_of(walk_cur, byte_r[bit_inc]);
    end
  end

  hfpd_node_ram #(
    .DEPTH (TREE_NODES),
    .AW    (AW)
  ) u_node_ram (
    .clk     (clk),
    .wr_en   (load_acc && load_in_range),
    .wr_addr (f_index[AW-1:0]),
    .wr_data (f_node),
    .rd_addr (rd_idx[AW-1:0]),
    .rd_data (rd_data)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (byte_acc) begin
          unique case (mode_r)
            MODE_HUFF:   state_nxt = S_WALK;
            MODE_RAW:    state_nxt = S_FLUSH;
            MODE_HEADER,
            MODE_BAD:    state_nxt = in_tlast ? S_FLUSH : S_IDLE;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_WALK: begin
        if (walk_done) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (flush_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    mode_nxt     = mode_r;
    pad_nxt      = pad_r;
    walk_nxt     = walk_r;
    in_code_nxt  = in_code_r;
    held_v_nxt   = held_v_r;
    held_sym_nxt = held_sym_r;
    cur_nxt      = cur_r;
    root_nxt     = root_r;
    byte_nxt     = byte_r;
    last_nxt     = last_r;
    bit_nxt      = bit_r;
    bit_end_nxt  = bit_end_r;
    out_v_nxt    = out_v_r && !out_tready;
    out_sym_nxt  = out_sym_r;
    out_sv_nxt   = out_sv_r;
    out_run_nxt  = out_run_r;
    out_pend_nxt = out_pend_r;
    out_stat_nxt = out_stat_r;

    unique case (state_r)
      S_IDLE: begin
        if (load_acc && load_in_range) begin
          if (f_index == 9'd0) begin
            root_nxt = f_node;
          end
          if (f_index == walk_r) begin
            cur_nxt = f_node;
          end
        end
        if (byte_acc) begin
          last_nxt = in_tlast;
          unique case (mode_r)
            MODE_HEADER: begin
              if (f_byte == HDR_RAW) begin
                mode_nxt = MODE_RAW;
              end else if (f_byte < HDR_PAD_LIM) begin
                mode_nxt = MODE_HUFF;
                pad_nxt  = f_byte[2:0];
              end else begin
                mode_nxt = MODE_BAD;
              end
            end
            MODE_HUFF: begin
              byte_nxt    = f_byte;
              bit_nxt     = 3'd0;
              bit_end_nxt = in_tlast ? (3'd7 - pad_r) : 3'd7;
            end
            MODE_RAW: begin
              held_v_nxt   = 1'b1;
              held_sym_nxt = f_byte;
            end
            MODE_BAD: begin
            end
            default: begin
            end
          endcase
        end
      end
      S_WALK: begin
        if (!walk_stall) begin
          if (fetched.leaf) begin
            // previous symbol of this byte is not the last one
            if (held_v_r) begin
              out_v_nxt    = 1'b1;
              out_sym_nxt  = held_sym_r;
              out_sv_nxt   = 1'b1;
              out_run_nxt  = 1'b0;
              out_pend_nxt = 1'b0;
              out_stat_nxt = STAT_OK;
            end
            held_v_nxt   = 1'b1;
            held_sym_nxt = fetched.symbol;
            walk_nxt     = 9'd0;
          end else begin
            walk_nxt = fetch_r;
          end
          cur_nxt     = walk_cur;
          in_code_nxt = !fetched.leaf;
          bit_nxt     = bit_inc;
        end
      end
      S_FLUSH: begin
        if (flush_go) begin
          if (flush_need_out) begin
            out_v_nxt    = 1'b1;
            out_sym_nxt  = held_v_r ? held_sym_r : 8'd0;
            out_sv_nxt   = held_v_r;
            out_run_nxt  = 1'b1;
            out_pend_nxt = last_r;
            out_stat_nxt = last_r ? end_stat : STAT_OK;
          end
          held_v_nxt = 1'b0;
          if (last_r) begin
            mode_nxt    = MODE_HEADER;
            pad_nxt     = 3'd0;
            walk_nxt    = 9'd0;
            cur_nxt     = root_r;
            in_code_nxt = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      mode_r    <= MODE_HEADER;
      pad_r     <= 3'd0;
      walk_r    <= 9'd0;
      in_code_r <= 1'b0;
      held_v_r  <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      mode_r    <= mode_nxt;
      pad_r     <= pad_nxt;
      walk_r    <= walk_nxt;
      in_code_r <= in_code_nxt;
      held_v_r  <= held_v_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

  // node under the walk; back to the root on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= root_r;
    end else begin
      cur_r <= cur_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    root_r     <= root_nxt;
    byte_r     <= byte_nxt;
    last_r     <= last_nxt;
    bit_r      <= bit_nxt;
    bit_end_r  <= bit_end_nxt;
    fetch_r    <= rd_idx;
    oor_r      <= !({1'b0, rd_idx} < NODES_LIM);
    held_sym_r <= held_sym_nxt;
    out_sym_r  <= out_sym_nxt;
    out_sv_r   <= out_sv_nxt;
    out_run_r  <= out_run_nxt;
    out_pend_r <= out_pend_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_sym_r;
  assign out_tuser  = {out_stat_r, out_run_r, out_sv_r};
  assign out_tlast  = out_pend_r;

endmodule

`default_nettype wire

FILE: src/hfpd_checker.sv
// Port-level checks on the decoder result channel, bound to the top level.
// Depends on huffman_packet_decoder_assert.svh for the assertion macros.
`timescale 1ns / 1ps
`default_nettype none

`include "huffman_packet_decoder_assert.svh"

module hfpd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [7:0]  out_tdata,
  input wire logic [3:0]  out_tuser,
  input wire logic        out_tlast
);

  // a held result stays put
  `HFPD_AST_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

  // a bare marker only closes a packet and carries no byte
  `HFPD_AST_IMP(a_bare_end, clk, rst_n, out_tvalid && !out_tuser[0], out_tlast && (out_tdata == 8'd0))

  // end of packet is always the last result of its input
  `HFPD_AST_IMP(a_end_run, clk, rst_n, out_tvalid && out_tlast, out_tuser[1])

  // status only at packet end, and never the unused code
  `HFPD_AST_IMP(a_stat_end, clk, rst_n, out_tvalid && (out_tuser[3:2] != 2'd0), out_tlast && (out_tuser[3:2] != 2'd3))

endmodule

bind huffman_packet_decoder hfpd_checker u_hfpd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire

FILE: tb/huffman_packet_decoder_checker.sv
// Checker for the Huffman packet decoder: watches both stream channels, predicts the results.
// It compares each result transfer in order and reports the error and pending counts.
// Depends on hfpd_pkg.
`timescale 1ns / 1ps

module huffman_packet_decoder_checker
  import hfpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic        in_tuser,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  input  logic [3:0]  out_tuser,
  input  logic        out_tlast,
  output int          errors,
  output int          pending
);

  localparam int NODE_COUNT = 512;

  typedef struct packed {
    logic [7:0] symbol;
    logic       sym_valid;
    logic       run_last;
    logic       packet_end;
    logic [1:0] status;
  } symbol_result_t;

  hfpd_node_t     tree_mem [0:NODE_COUNT-1];
  logic [8:0]     walk_idx;
  hfpd_mode_t     pkt_mode;
  logic [2:0]     pad_count;
  logic           mid_code;
  symbol_result_t symbols_due [$];

  function automatic hfpd_node_t fetch_node(input logic [8:0] idx);
    if (idx < NODE_COUNT) return tree_mem[idx];
    return '0;
  endfunction

  function automatic symbol_result_t make_result(input logic [7:0] sym, input logic valid,
                                                 input logic pend, input logic [1:0] st);
    symbol_result_t r;
    r.symbol     = sym;
    r.sym_valid  = valid;
    r.run_last   = 1'b0;
    r.packet_end = pend;
    r.status     = st;
    return r;
  endfunction

  task automatic end_packet();
    pkt_mode  = MODE_HEADER;
    walk_idx  = '0;
    pad_count = '0;
    mid_code  = 1'b0;
  endtask

  task automatic decode_transfer(input logic op, input logic [47:0] d, input logic last);
    hfpd_node_t     cur;
    hfpd_node_t     nxt;
    logic [8:0]     next_idx;
    logic [7:0]     pkt;
    logic [1:0]     st;
    symbol_result_t run_buf [0:8];
    symbol_result_t tmp;
    int             n;
    int             nbits;
    int             i;
    n   = 0;
    pkt = d[43:36];
    if (op == OP_LOAD) begin
      if (d[8:0] < NODE_COUNT)
        tree_mem[d[8:0]] = {d[9], d[18:10], d[27:19], d[35:28]};
    end else begin
      case (pkt_mode)
        MODE_HEADER: begin
          if (pkt == HDR_RAW) begin
            pkt_mode = MODE_RAW;
          end else if (pkt < HDR_PAD_LIM) begin
            pkt_mode  = MODE_HUFF;
            pad_count = pkt[2:0];
          end else begin
            pkt_mode = MODE_BAD;
          end
          if (last) begin
            run_buf[n] = make_result(8'h00, 1'b0, 1'b1,
                                     (pkt_mode == MODE_BAD) ? STAT_BADHDR : STAT_OK);
            n++;
            end_packet();
          end
        end
        MODE_RAW: begin
          run_buf[n] = make_result(pkt, 1'b1, last, STAT_OK);
          n++;
          if (last) end_packet();
        end
        MODE_BAD: begin
          if (last) begin
            run_buf[n] = make_result(8'h00, 1'b0, 1'b1, STAT_BADHDR);
            n++;
            end_packet();
          end
        end
        default: begin
          nbits = last ? 8 - pad_count : 8;
          // bits taken lsb first; a leaf sends the walk back to the root
          for (i = 0; i < nbits; i++) begin
            cur      = fetch_node(walk_idx);
            next_idx = pkt[i] ? cur.one_child : cur.zero_child;
            nxt      = fetch_node(next_idx);
            if (nxt.leaf) begin
              run_buf[n] = make_result(nxt.symbol, 1'b1, 1'b0, STAT_OK);
              n++;
              walk_idx = '0;
              mid_code = 1'b0;
            end else begin
              walk_idx = next_idx;
              mid_code = 1'b1;
            end
          end
          if (last) begin
            st = mid_code ? STAT_CUT : STAT_OK;
            if (n > 0) begin
              tmp            = run_buf[n-1];
              tmp.packet_end = 1'b1;
              tmp.status     = st;
              run_buf[n-1]   = tmp;
            end else begin
              run_buf[n] = make_result(8'h00, 1'b0, 1'b1, st);
              n++;
            end
            end_packet();
          end
        end
      endcase
      if (n > 0) begin
        tmp          = run_buf[n-1];
        tmp.run_last = 1'b1;
        run_buf[n-1] = tmp;
      end
      for (i = 0; i < n; i++) symbols_due.push_back(run_buf[i]);
    end
  endtask

  initial begin
    errors  = 0;
    pending = 0;
    end_packet();
  end

  always @(posedge clk) begin
    symbol_result_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) decode_transfer(in_tuser, in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (symbols_due.size() == 0) begin
          $error("unexpected result transfer: symbol %0h user %0h", out_tdata, out_tuser);
          errors++;
        end else begin
          want = symbols_due.pop_front();
          if (out_tdata !== want.symbol) begin
            $error("symbol: expected %0h, got %0h", want.symbol, out_tdata);
            errors++;
          end
          if (out_tuser[0] !== want.sym_valid) begin
            $error("symbol_valid: expected %0d, got %0d", want.sym_valid, out_tuser[0]);
            errors++;
          end
          if (out_tuser[1] !== want.run_last) begin
            $error("run_last: expected %0d, got %0d", want.run_last, out_tuser[1]);
            errors++;
          end
          if (out_tlast !== want.packet_end) begin
            $error("packet_end: expected %0d, got %0d", want.packet_end, out_tlast);
            errors++;
          end
          if (out_tuser[3:2] !== want.status) begin
            $error("end_status: expected %0d, got %0d", want.status, out_tuser[3:2]);
            errors++;
          end
        end
      end
    end
    pending = symbols_due.size();
  end

endmodule

FILE: tb/huffman_packet_decoder_test.sv
// Top of the Huffman packet decoder testbench: clock, reset, tree loads and packet stimulus.
// Directed packets first, then random trees and packets; the checker does all comparison.
// Depends on hfpd_pkg, huffman_packet_decoder and huffman_packet_decoder_checker.
`timescale 1ns / 1ps

module huffman_packet_decoder_test;
  import hfpd_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_ITEMS = 230;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic [3:0]  out_tuser;
  logic        out_tlast;
  int          errors;
  int          pending;

  int burst_left = 0;
  int items_sent = 0;
  int cycle_count = 0;
  int ready_pct = 100;
  int stall_tick = 0;
  bit is_written [0:511];
  int written_q [$];

  always #6 clk = ~clk;

  huffman_packet_decoder #(.TREE_NODES(512)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  huffman_packet_decoder_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .errors(errors), .pending(pending)
  );

  // receiver: ready odds are redrawn at intervals set by stall_tick
  always @(posedge clk) begin
    stall_tick++;
    if (stall_tick % 64 == 0) begin
      case ($urandom_range(0, 2))
        0: ready_pct = 100;
        1: ready_pct = 75;
        default: ready_pct = 35;
      endcase
    end
    out_tready <= ($urandom_range(0, 99) < ready_pct);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  task automatic push_transfer(input logic op, input logic [47:0] data, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= data;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic load_node(input int idx, input logic leaf, input int zc, input int oc,
                           input logic [7:0] sym);
    logic [47:0] w;
    w = {4'h0, 8'($urandom_range(0, 255)), sym, 9'(oc), 9'(zc), leaf, 9'(idx)};
    if (!is_written[idx]) begin
      is_written[idx] = 1'b1;
      written_q.push_back(idx);
    end
    push_transfer(OP_LOAD, w, 1'($urandom_range(0, 1)));
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    logic [47:0] w;
    w = {4'h0, b, 36'({$urandom, $urandom})};
    push_transfer(OP_BYTE, w, last);
  endtask

  // children drawn only from loaded nodes, so no walk reads an unloaded one
  task automatic stray_load();
    load_node($urandom_range(0, 511), 1'($urandom_range(0, 1)),
              written_q[$urandom_range(0, written_q.size() - 1)],
              written_q[$urandom_range(0, written_q.size() - 1)],
              8'($urandom_range(0, 255)));
  endtask

  // random full binary tree rooted at node 0, grown by splitting leaves
  task automatic build_tree(input int leaves);
    int leaf_q [$];
    bit taken [0:511];
    int kids [0:1];
    int pick;
    int idx;
    int k;
    taken[0] = 1'b1;
    leaf_q.push_back(0);
    repeat (leaves - 1) begin
      pick = $urandom_range(0, leaf_q.size() - 1);
      idx  = leaf_q[pick];
      leaf_q.delete(pick);
      for (k = 0; k < 2; k++) begin
        do kids[k] = $urandom_range(1, 511); while (taken[kids[k]]);
        taken[kids[k]] = 1'b1;
        leaf_q.push_back(kids[k]);
      end
      // leaf mark of the root is looked at only when node 0 is reached as a child
      load_node(idx, (idx == 0) ? 1'($urandom_range(0, 1)) : 1'b0, kids[0], kids[1],
                8'($urandom_range(0, 255)));
    end
    foreach (leaf_q[k])
      load_node(leaf_q[k], 1'b1, $urandom_range(0, 511), $urandom_range(0, 511),
                8'($urandom_range(0, 255)));
  endtask

  // stop sending, then wait until every expected result has come
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int packet_no;
    int nbytes;
    int k;
    int r;
    logic [7:0] hdr;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // root marked leaf; node 2 leads back to the root on a one bit
    load_node(0, 1'b1, 1, 2, 8'h5a);
    load_node(1, 1'b1, 0, 0, 8'h00);
    load_node(2, 1'b0, 511, 0, 8'h00);
    load_node(511, 1'b1, 511, 511, 8'hff);
    send_byte(HDR_RAW, 1'b1);              // raw header alone
    send_byte(8'h03, 1'b1);                // Huffman header alone, padding unused
    send_byte(HDR_PAD_LIM, 1'b1);          // bad header alone
    send_byte(8'hfe, 1'b0);                // bad packet swallowed
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b1);
    send_byte(HDR_RAW, 1'b0);              // raw pass-through
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(8'h00, 1'b0);                // eight symbols from one byte
    send_byte(8'h00, 1'b1);
    send_byte(8'h07, 1'b0);                // seven padding bits
    send_byte(8'hff, 1'b0);
    load_node(3, 1'b1, 1, 1, 8'h80);       // load inside a packet
    send_byte(8'h01, 1'b1);                // cut-off code, no symbol
    send_byte(8'h00, 1'b0);
    send_byte(8'haa, 1'b1);                // cut-off code after symbols
    send_byte(8'h06, 1'b0);
    send_byte(8'h00, 1'b1);
    wait_drained();

    items_sent = 0;
    packet_no  = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (packet_no % 8 == 0) build_tree((packet_no % 16 == 0) ? 2 : $urandom_range(2, 8));
      r = $urandom_range(0, 99);
      if (r < 70) hdr = 8'($urandom_range(0, 7));
      else if (r < 85) hdr = HDR_RAW;
      else hdr = 8'($urandom_range(8, 254));
      nbytes = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
      send_byte(hdr, nbytes == 0);
      for (k = 0; k < nbytes; k++) begin
        if ($urandom_range(0, 19) == 0) stray_load();
        send_byte(8'($urandom_range(0, 255)), k == nbytes - 1);
        if (hdr != HDR_RAW && hdr >= HDR_PAD_LIM) items_sent--;  // swallowed bytes
      end
      packet_no++;
      if (packet_no == 15) wait_drained();
    end
    in_tvalid <= 1'b0;

    wait_drained();
    repeat (30) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/hfpd_pkg.sv
src/hfpd_node_ram.sv
src/huffman_packet_decoder.sv
src/hfpd_checker.sv
tb/huffman_packet_decoder_checker.sv
tb/huffman_packet_decoder_test.sv
